// ===== rtl/core/fla_pkg.sv =====
// Shared types and constants for the free-list slot allocator.
// No dependencies; every other file in rtl/core but fla_ram refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package fla_pkg;

    // Default size of the slot table.
    localparam int unsigned SLOT_COUNT_DEFAULT = 4096;

    // Field widths fixed by the request and result formats.
    localparam int unsigned SLOT_FIELD_W = 12;
    localparam int unsigned STATUS_W     = 2;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

    // Request payload.
    typedef struct packed {
        logic                    operation;
        logic [SLOT_FIELD_W-1:0] slot_index;
    } fla_req_t;

    // Result payload.
    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] granted_slot;
        logic [STATUS_W-1:0]     status;
    } fla_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request and start the link read
        logic commit;   // update the allocator state and load the result
    } fla_cmd_t;

    // Controller states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } fla_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/free_list_slot_allocator_unit.sv =====
// Free-list slot allocator for a table of SLOT_COUNT slots.
// Request and result channels use valid/ready. A request carries an operation
// (allocate, or free the slot in slot_index); every request yields one result
// with the granted slot and a status (ok, table full, bad index).
// An accepted request is latched along with the registered link RAM read of the
// chain head, and its result is loaded into the result register once that is
// free. A new request is taken only after the last one has committed, since an
// allocate needs the link RAM read before the chain head can move.
// Allocation is last-in first-out: the most recently freed slot is handed out
// first; with no freed slot, the next never-used slot is taken from a
// high-water counter. Double frees are not detected.
// Reset: the free chain is empty and the high-water counter is zero. The link
// RAM is not cleared and needs no clearing pass; requests are taken as soon as
// reset is released.
// Stall: while the receiver holds ready low the result stays registered; one
// further request is accepted and held until the result register frees.
// Depends on fla_pkg, fla_ctrl, fla_datapath and fla_ram.
`timescale 1ns / 1ps
`default_nettype none

module free_list_slot_allocator_unit #(
    parameter int unsigned SLOT_COUNT = fla_pkg::SLOT_COUNT_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire fla_pkg::fla_req_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output fla_pkg::fla_rsp_t      m_data
);

    fla_pkg::fla_cmd_t cmd;

    // Sequencing of requests and results.
    fla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Allocator state and result computation.
    fla_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/fla_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fla_ram #(
    parameter int unsigned DATA_W = 13,
    parameter int unsigned DEPTH  = 4096,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fla_ctrl.sv =====
// Controller of the free-list slot allocator: request sequencing and result valid.
// Depends on fla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fla_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    output fla_pkg::fla_cmd_t  cmd
);

    fla_pkg::fla_state_t state_reg;
    fla_pkg::fla_state_t state_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic                out_free;

    // The result register can take a new result when empty or being emptied.
    assign out_free = !m_valid_reg || m_ready;

    // State and result valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fla_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.commit   = 1'b0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            fla_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = fla_pkg::ST_EXEC;
                end
            end
            fla_pkg::ST_EXEC: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = fla_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fla_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    // A captured request is always followed by the execute state.
    a_capture_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == fla_pkg::ST_EXEC))
        else $error("capture not followed by execute state");

    // A commit never overwrites a result that has not been taken.
    a_commit_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("commit while result register busy");

    // The result valid only rises after a commit.
    a_valid_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.commit))
        else $error("result valid raised without commit");

endmodule

`default_nettype wire

// ===== rtl/core/fla_datapath.sv =====
// Datapath of the free-list slot allocator: head, high-water mark, link RAM, result.
// Depends on fla_pkg and fla_ram.
`timescale 1ns / 1ps
`default_nettype none

module fla_datapath #(
    parameter int unsigned SLOT_COUNT = fla_pkg::SLOT_COUNT_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire fla_pkg::fla_cmd_t cmd,
    input  wire fla_pkg::fla_req_t s_data,
    output fla_pkg::fla_rsp_t     m_data
);

    localparam int unsigned ADDR_W = $clog2(SLOT_COUNT);
    localparam int unsigned LINK_W = $clog2(SLOT_COUNT + 1);
    localparam int unsigned SF_W   = fla_pkg::SLOT_FIELD_W;
    localparam int unsigned CMP_W  = LINK_W + SF_W;
    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(SLOT_COUNT);

    fla_pkg::fla_req_t  req_reg;
    fla_pkg::fla_rsp_t  rsp_reg;
    fla_pkg::fla_rsp_t  rsp_next;
    logic [LINK_W-1:0]  head_reg;
    logic [LINK_W-1:0]  head_next;
    logic [LINK_W-1:0]  hw_reg;
    logic [LINK_W-1:0]  hw_next;
    logic [LINK_W-1:0]  link_rdata;
    logic [LINK_W-1:0]  link_clamped;
    logic               link_we;
    logic [ADDR_W-1:0]  free_addr;
    logic [ADDR_W+SF_W-1:0] idx_wide;
    logic [ADDR_W+SF_W-1:0] grant_wide;
    logic [LINK_W-1:0]  grant_slot;
    logic               chain_nonempty;
    logic               idx_bad;

    // Link store: one entry per slot, holding the next free slot or the end mark.
    fla_ram #(
        .DATA_W (LINK_W),
        .DEPTH  (SLOT_COUNT)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (free_addr),
        .wdata (head_reg),
        .re    (cmd.capture),
        .raddr (head_reg[ADDR_W-1:0]),
        .rdata (link_rdata)
    );

    // Request register.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
    end

    // Decode of the captured request against the current state.
    assign chain_nonempty = (head_reg != END_MARK);
    assign idx_bad        = ({LINK_W'(0), req_reg.slot_index} >= CMP_W'(hw_reg));
    assign idx_wide       = {ADDR_W'(0), req_reg.slot_index};
    assign free_addr      = idx_wide[ADDR_W-1:0];
    assign link_clamped   = (link_rdata > END_MARK) ? END_MARK : link_rdata;
    assign link_we        = cmd.commit && (req_reg.operation == fla_pkg::OP_FREE) && !idx_bad;

    // Next head, high-water mark and result.
    always_comb begin
        head_next  = head_reg;
        hw_next    = hw_reg;
        grant_slot = '0;
        rsp_next.status = fla_pkg::STATUS_OK;
        if (req_reg.operation == fla_pkg::OP_ALLOC) begin
            if (chain_nonempty) begin
                grant_slot = head_reg;
                head_next  = link_clamped;
            end else if (hw_reg != END_MARK) begin
                grant_slot = hw_reg;
                hw_next    = hw_reg + LINK_W'(1);
            end else begin
                rsp_next.status = fla_pkg::STATUS_FULL;
            end
        end else begin
            if (idx_bad) begin
                rsp_next.status = fla_pkg::STATUS_BAD_INDEX;
            end else begin
                head_next = LINK_W'(free_addr);
            end
        end
        grant_wide            = (ADDR_W + SF_W)'(grant_slot);
        rsp_next.granted_slot = grant_wide[SF_W-1:0];
    end

    // Allocator state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= END_MARK;
            hw_reg   <= '0;
        end else if (cmd.commit) begin
            head_reg <= head_next;
            hw_reg   <= hw_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_data = rsp_reg;

    // The high-water mark never passes the table size.
    a_hw_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        hw_reg <= END_MARK)
        else $error("high-water mark beyond table size");

    // The head is either the end mark or a slot already handed out.
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == END_MARK) || (head_reg < hw_reg))
        else $error("free head names a slot never handed out");

    // A fresh slot from the high-water counter advances the counter by one.
    a_hw_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (req_reg.operation == fla_pkg::OP_ALLOC) && !chain_nonempty
         && (hw_reg != END_MARK)) |=> (hw_reg == $past(hw_reg) + LINK_W'(1)))
        else $error("high-water counter did not advance");

endmodule

`default_nettype wire

// ===== test/free_list_allocator_checker.sv =====
// Scoreboard for the free-list slot allocator: watches both channels,
// predicts each result from its own copy of the chain and compares.
// Depends on fla_pkg for the request and result types and the codes.
`timescale 1ns / 1ps

module free_list_allocator_checker #(
    parameter int unsigned SLOT_COUNT = fla_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  fla_pkg::fla_req_t s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  fla_pkg::fla_rsp_t m_data,
    output int                fail_count,
    output int                pending_results
);

    import fla_pkg::*;

    // Links and the head must also hold the end mark, which is SLOT_COUNT.
    localparam int unsigned       LINK_W   = $clog2(SLOT_COUNT + 1);
    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(SLOT_COUNT);

    logic [LINK_W-1:0] next_free [SLOT_COUNT];
    logic [LINK_W-1:0] chain_head;
    logic [LINK_W-1:0] high_water;
    fla_rsp_t          awaited_results [$];

    // Applies one request to the shadow chain and returns the result it earns.
    function automatic fla_rsp_t predict_allocation(input fla_req_t req);
        fla_rsp_t rsp;
        rsp.granted_slot = '0;
        rsp.status       = STATUS_OK;
        if (req.operation == OP_ALLOC) begin
            if (chain_head != END_MARK) begin
                // Pop the most recently freed slot.
                rsp.granted_slot = SLOT_FIELD_W'(chain_head);
                chain_head       = next_free[chain_head];
            end else if (high_water != END_MARK) begin
                // Chain empty: hand out the next never-used slot.
                rsp.granted_slot = SLOT_FIELD_W'(high_water);
                high_water       = high_water + 1'b1;
            end else begin
                rsp.status = STATUS_FULL;
            end
        end else begin
            // The index is compared at full width, whatever the table size.
            if (32'(req.slot_index) >= 32'(high_water)) begin
                rsp.status = STATUS_BAD_INDEX;
            end else begin
                // Push the slot; a double free is pushed like any other.
                next_free[req.slot_index] = chain_head;
                chain_head                = LINK_W'(req.slot_index);
            end
        end
        return rsp;
    endfunction

    // Results are compared before the request of the same edge is predicted,
    // since a result always belongs to an earlier request.
    always @(posedge aclk) begin
        fla_rsp_t want;
        if (!aresetn) begin
            chain_head = END_MARK;
            high_water = '0;
            awaited_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with no request outstanding, got slot %0d status %0d",
                             $time, m_data.granted_slot, m_data.status);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_data.granted_slot !== want.granted_slot) begin
                        fail_count++;
                        $display("%0t: granted_slot expected %0d, got %0d",
                                 $time, want.granted_slot, m_data.granted_slot);
                    end
                    if (m_data.status !== want.status) begin
                        fail_count++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_data.status);
                    end
                end
            end
            if (s_valid && s_ready) begin
                awaited_results.push_back(predict_allocation(s_data));
            end
        end
        pending_results <= awaited_results.size();
    end

endmodule

// ===== test/tb_free_list_slot_allocator_unit.sv =====
// Top of the allocator testbench: clock, reset, request stimulus and verdict.
// Depends on fla_pkg, free_list_slot_allocator_unit and free_list_allocator_checker.
`timescale 1ns / 1ps

module tb_free_list_slot_allocator_unit;

    import fla_pkg::*;

    localparam int unsigned SLOT_COUNT  = SLOT_COUNT_DEFAULT;
    localparam int unsigned CYCLE_LIMIT = 400_000;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    fla_req_t s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    fla_rsp_t m_data;

    int fail_count;
    int pending_results;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          calm          = 1'b0;
    int unsigned requests_sent = 0;
    int unsigned allocs_issued = 0;
    int unsigned cycle_count   = 0;

    // Slots known to be held, so that frees stay legal until the double free.
    logic                    ops_in_flight [$];
    logic [SLOT_FIELD_W-1:0] held_slots [$];

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    free_list_slot_allocator_unit #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    free_list_allocator_checker #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .fail_count     (fail_count),
        .pending_results(pending_results)
    );

    // Receiver stalls at random, except during calm stretches.
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= recv_idle_pct);
    end

    // Track granted slots to steer the stimulus.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready && ops_in_flight.size() > 0) begin
                if (ops_in_flight.pop_front() == OP_ALLOC) begin
                    if (m_data.status == STATUS_OK) begin
                        held_slots.push_back(m_data.granted_slot);
                    end
                end
            end
            if (s_valid && s_ready) begin
                ops_in_flight.push_back(s_data.operation);
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** free_list_slot_allocator_unit: FAILED **");
            $finish;
        end
    end

    // Presents one request, after an optional gap, and waits for acceptance.
    task automatic send_request(input logic op, input logic [SLOT_FIELD_W-1:0] idx);
        int unsigned gap;
        gap  = 0;
        calm = (requests_sent % 64) < 12;
        if (!calm) begin
            while ($urandom_range(99) < send_idle_pct) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_data.operation  <= op;
        s_data.slot_index <= idx;
        if (op == OP_ALLOC) allocs_issued++;
        requests_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Holds off the sender until every outstanding result has returned.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    task automatic alloc_request();
        send_request(OP_ALLOC, SLOT_FIELD_W'($urandom));
    endtask

    // Frees a randomly chosen held slot, or allocates when none is held.
    task automatic free_held_slot();
        int unsigned             pick;
        logic [SLOT_FIELD_W-1:0] slot;
        if (held_slots.size() == 0) begin
            alloc_request();
        end else begin
            pick = $urandom_range(held_slots.size() - 1);
            slot = held_slots[pick];
            held_slots.delete(pick);
            send_request(OP_FREE, slot);
        end
    endtask

    // Well-formed traffic: allocates and frees of held slots in equal measure.
    task automatic churn(input int unsigned count);
        for (int unsigned n = 0; n < count; n++) begin
            if ($urandom_range(1) == 0) alloc_request();
            else free_held_slot();
        end
    endtask

    initial begin
        int unsigned             roll;
        logic [SLOT_FIELD_W-1:0] repeated_slot;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // First phase: sender idles often, receiver stalls more.
        send_idle_pct = 32;
        recv_idle_pct = 67;

        // Bad index on an empty table, at both ends of the index range.
        send_request(OP_FREE, '0);
        send_request(OP_FREE, '1);
        // Fresh slots come from the high-water counter.
        send_request(OP_ALLOC, '1);
        alloc_request();
        alloc_request();
        // Index equal to the high-water mark is still bad.
        send_request(OP_FREE, SLOT_FIELD_W'(3));
        // Free onto an empty chain, then onto a non-empty one.
        send_request(OP_FREE, SLOT_FIELD_W'(2));
        send_request(OP_FREE, SLOT_FIELD_W'(0));
        // Pop in last-in first-out order, then fall back to the counter.
        alloc_request();
        alloc_request();
        alloc_request();
        send_request(OP_FREE, SLOT_FIELD_W'(1));
        send_request(OP_FREE, SLOT_FIELD_W'(3));
        send_request(OP_ALLOC, '0);
        alloc_request();
        alloc_request();
        drain_results();

        // Every slot handed out so far is held again.
        held_slots.delete();
        for (int s = 0; s < 5; s++) held_slots.push_back(SLOT_FIELD_W'(s));

        // Mixed traffic with bad-index frees above anything yet handed out.
        for (int unsigned n = 0; n < 130; n++) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
                alloc_request();
            end else if (roll < 80) begin
                free_held_slot();
            end else begin
                send_request(OP_FREE, SLOT_FIELD_W'($urandom_range(SLOT_COUNT - 1,
                                                                    allocs_issued)));
            end
        end
        drain_results();

        // Second phase: roles of sender and receiver swapped.
        send_idle_pct = 67;
        recv_idle_pct = 32;
        churn(130);
        drain_results();

        // Last phase: no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        churn(120);
        alloc_request();
        drain_results();

        // Double free: the slot then links to itself and keeps coming back.
        repeated_slot = held_slots[$urandom_range(held_slots.size() - 1)];
        send_request(OP_FREE, repeated_slot);
        send_request(OP_FREE, repeated_slot);
        repeat (3) alloc_request();
        for (int unsigned n = 0; n < 8; n++) begin
            send_request(($urandom_range(1) == 0) ? OP_ALLOC : OP_FREE,
                         SLOT_FIELD_W'($urandom));
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** free_list_slot_allocator_unit: PASSED **");
        end else begin
            $display("** free_list_slot_allocator_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fla_pkg.sv
rtl/core/fla_ram.sv
rtl/core/fla_ctrl.sv
rtl/core/fla_datapath.sv
rtl/core/free_list_slot_allocator_unit.sv
test/free_list_allocator_checker.sv
test/tb_free_list_slot_allocator_unit.sv
